// File: design/gdil3_pkg.sv
// Shared types, constants and helpers of the 3x3 grayscale dilation block.
package gdil3_pkg;

  localparam int PIX_W    = 8;
  localparam int WIDTH_W  = 11;
  localparam int HEIGHT_W = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd640;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 13'd480;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef logic [PIX_W-1:0] pix_t;

  typedef struct packed {
    pix_t col_max;
    logic win;
    logic eol;
    logic eof;
  } item_t;

  function automatic pix_t max8(input pix_t a, input pix_t b);
    return (a > b) ? a : b;
  endfunction

endpackage

// File: design/grayscale_dilation_3x3_core.sv
// Top level of the 3x3 grayscale dilation (max filter) over a bordered pixel stream.
//
//   Channel   Handshake            Payload
//   in_       in_push / in_full    in_pixel
//   out_      out_empty / out_pop  out_dilated, out_end_of_line, out_end_of_frame
//   cfg_      cfg_valid / cfg_ready  cfg_index, cfg_wdata
//
// One pixel word is accepted every clock cycle while in_full is low; the line
// store port and the front-to-back queue sustain that rate. A result word is
// registered behind the stage-one register and the queue. Reset clears positions
// and column maxima; the line store is not cleared, so the block takes pixels
// right after reset. A stalled result fills the queue and then raises in_full.
module grayscale_dilation_3x3_core import gdil3_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  output logic                  in_full,
  input  pix_t                  in_pixel,
  output logic                  out_empty,
  input  logic                  out_pop,
  output pix_t                  out_dilated,
  output logic                  out_end_of_line,
  output logic                  out_end_of_frame,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic              q_push, q_pop, q_valid;
  item_t             q_in, q_head;
  logic [QCNT_W-1:0] q_count;

  gdil3_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_pixel  (in_pixel),
    .in_full   (in_full),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_count   (q_count),
    .q_push    (q_push),
    .q_item    (q_in)
  );

  gdil3_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_head),
    .count     (q_count)
  );

  gdil3_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_head           (q_head),
    .q_pop            (q_pop),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_dilated      (out_dilated),
    .out_end_of_line  (out_end_of_line),
    .out_end_of_frame (out_end_of_frame)
  );

endmodule

// File: design/gdil3_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module gdil3_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: design/gdil3_front.sv
// Front part: accepts pixels, tracks position, updates the line stores and forms column maxima.
module gdil3_front import gdil3_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  input  pix_t                  in_pixel,
  output logic                  in_full,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic [QCNT_W-1:0]     q_count,
  output logic                  q_push,
  output item_t                 q_item
);

  localparam int DEPTH = MAX_WIDTH + 2;
  localparam int CW = $clog2(MAX_WIDTH + 2);
  localparam int RW = $clog2(MAX_HEIGHT + 2);
  localparam logic [31:0] MAXW = 32'(MAX_WIDTH);
  localparam logic [31:0] MAXH = 32'(MAX_HEIGHT);

  logic [WIDTH_W-1:0]  width_r;
  logic [HEIGHT_W-1:0] height_r;
  logic [CW-1:0]       col_r, col_nxt;
  logic [RW-1:0]       row_r, row_nxt;
  logic                s1_v_r;
  pix_t                s1_px_r;
  logic [CW-1:0]       s1_col_r;
  logic                s1_win_r, s1_eol_r, s1_eof_r;

  logic [CW-1:0] eff_w, last_col;
  logic [RW-1:0] eff_h, last_row;
  logic          accept, cfg_hit, eol, eof, win;
  logic [2*PIX_W-1:0] rd_data;
  pix_t          up_px, mid_px;

  always_comb begin
    if (width_r == '0) begin
      eff_w = CW'(1);
    end else if (32'(width_r) > MAXW) begin
      eff_w = CW'(MAX_WIDTH);
    end else begin
      eff_w = CW'(width_r);
    end
    if (height_r == '0) begin
      eff_h = RW'(1);
    end else if (32'(height_r) > MAXH) begin
      eff_h = RW'(MAX_HEIGHT);
    end else begin
      eff_h = RW'(height_r);
    end
  end

  assign last_col = eff_w + CW'(1);
  assign last_row = eff_h + RW'(1);

  assign in_full   = ({1'b0, q_count} + (QCNT_W + 1)'(s1_v_r)) >= (QCNT_W + 1)'(QDEPTH);
  assign accept    = in_push && !in_full;
  assign cfg_ready = 1'b1;
  assign cfg_hit   = cfg_valid && cfg_ready &&
                     (cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT);

  assign eol = col_r >= last_col;
  assign eof = eol && (row_r >= last_row);
  assign win = (row_r >= RW'(2)) && (col_r >= CW'(2));

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (cfg_hit) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (accept) begin
      if (eol) begin
        col_nxt = '0;
        row_nxt = eof ? '0 : row_r + RW'(1);
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
      col_r    <= '0;
      row_r    <= '0;
      s1_v_r   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready && cfg_index == REG_IMAGE_WIDTH) begin
        width_r <= cfg_wdata[WIDTH_W-1:0];
      end
      if (cfg_valid && cfg_ready && cfg_index == REG_IMAGE_HEIGHT) begin
        height_r <= cfg_wdata[HEIGHT_W-1:0];
      end
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      s1_v_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_px_r  <= in_pixel;
      s1_col_r <= col_r;
      s1_win_r <= win;
      s1_eol_r <= eol;
      s1_eof_r <= eof;
    end
  end

  // Each entry holds the pixel two rows up in the high byte and one row up in the low byte.
  gdil3_ram #(
    .WIDTH (2 * PIX_W),
    .DEPTH (DEPTH)
  ) u_line_store (
    .clk     (clk),
    .wr_en   (s1_v_r),
    .wr_addr (s1_col_r),
    .wr_data ({mid_px, s1_px_r}),
    .rd_en   (accept),
    .rd_addr (col_r),
    .rd_data (rd_data)
  );

  assign up_px  = rd_data[2*PIX_W-1:PIX_W];
  assign mid_px = rd_data[PIX_W-1:0];

  assign q_push         = s1_v_r;
  assign q_item.col_max = max8(max8(up_px, mid_px), s1_px_r);
  assign q_item.win     = s1_win_r;
  assign q_item.eol     = s1_eol_r;
  assign q_item.eof     = s1_eof_r;

  a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    col_r <= last_col || $past(cfg_hit))
    else $error("column position passed the end of the stream row");

  a_eof_wraps: assert property (@(posedge clk) disable iff (!rst_n)
    accept && eof && !cfg_hit |=> col_r == '0 && row_r == '0)
    else $error("positions did not wrap after the last pixel of a frame");

endmodule

// File: design/gdil3_queue.sv
// Short word queue between the front and back parts.
module gdil3_queue import gdil3_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  item_t             push_item,
  input  logic              pop,
  output logic              valid,
  output item_t             head,
  output logic [QCNT_W-1:0] count
);

  item_t             slot_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r;

  assign valid = count_r != '0;
  assign head  = slot_r[rd_ptr_r];
  assign count = count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      count_r <= count_r + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (count_r < QCNT_W'(QDEPTH) || pop))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> count_r != '0)
    else $error("queue read while empty");

endmodule

// File: design/gdil3_back.sv
// Back part: combines column maxima into the window maximum and holds the result word.
module gdil3_back import gdil3_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  q_valid,
  input  item_t q_head,
  output logic  q_pop,
  output logic  out_empty,
  input  logic  out_pop,
  output pix_t  out_dilated,
  output logic  out_end_of_line,
  output logic  out_end_of_frame
);

  pix_t left_r, centre_r;
  logic out_v_r;
  pix_t out_dil_r;
  logic out_eol_r, out_eof_r;
  logic adv;
  pix_t win_max;

  assign adv     = q_valid && (!out_v_r || out_pop);
  assign q_pop   = adv;
  assign win_max = max8(max8(left_r, centre_r), q_head.col_max);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r   <= '0;
      centre_r <= '0;
      out_v_r  <= 1'b0;
    end else begin
      if (adv) begin
        left_r   <= centre_r;
        centre_r <= q_head.col_max;
        out_v_r  <= q_head.win;
      end else if (out_pop) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && q_head.win) begin
      out_dil_r <= win_max;
      out_eol_r <= q_head.eol;
      out_eof_r <= q_head.eof;
    end
  end

  assign out_empty        = !out_v_r;
  assign out_dilated      = out_dil_r;
  assign out_end_of_line  = out_eol_r;
  assign out_end_of_frame = out_eof_r;

  a_eof_has_eol: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (!out_eof_r || out_eol_r))
    else $error("end of frame without end of line");

endmodule
